// File: hw/rtl/tiny_mlp_batch_trainer_core_defines.svh
// Assertion macros for the trainer core.
`ifndef TINY_MLP_BATCH_TRAINER_CORE_DEFINES_SVH
`define TINY_MLP_BATCH_TRAINER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TMB_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TMB_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TMB_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TMB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/tmb_pkg.sv
package tmb_pkg;
  localparam int NUM_PARAMS = 9;
  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 40;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_INFER = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample_x1;
    logic signed [15:0] sample_x2;
    logic signed [15:0] target_value;
    logic               last_in_batch;
    logic [3:0]         param_index;
    logic signed [15:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic [14:0] prediction;
    logic [31:0] squared_error;
    logic [39:0] batch_loss;
    logic        loss_valid;
  } out_item_t;
endpackage

// File: hw/rtl/tiny_mlp_batch_trainer_core.sv
// Tiny 2-2-1 ReLU network trainer core.
// Input channel (in_valid/in_ready/in_item) takes one item: a training
// sample, an inference sample or a parameter load. The result channel
// (out_valid/out_ready/out_item) returns exactly one item per input item.
// All multiplies but the low half of the update product run through one
// shared 18x18 multiplier under a small sequencer, one multiply per step
// with a register after each product. A training sample runs 11 forward
// steps, 11 gradient steps and one result step before it returns to idle;
// the last sample of a batch adds an update pass of a multiply step and an
// apply step for each parameter. An inference sample runs only the forward
// steps; a load or an unused code goes straight to the result step.
// in_ready is high whenever the sequencer is idle. A finished item waits in
// the result step until the result register is free, so a stalled receiver
// holds one result at the output and at most one more inside the block.
// cfg_we writes learn_rate at any clock edge; use it while idle.
// Synchronous active-low reset clears parameters, gradient sums, loss and
// sets learn_rate to 655; the result register comes up empty.
`include "tiny_mlp_batch_trainer_core_defines.svh"
module tiny_mlp_batch_trainer_core #(
  parameter int FRAC_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tmb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tmb_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  localparam int DW = tmb_pkg::DATA_WIDTH;
  localparam int ACC_WIDTH = tmb_pkg::ACC_WIDTH;
  localparam int MW = DW + 2;
  localparam int PW = 2 * MW;
  localparam int NP = tmb_pkg::NUM_PARAMS;
  localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [ACC_WIDTH-1:0] LMAX = {ACC_WIDTH{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FWD  = 5'b00010,
    S_GRAD = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r;
  logic [3:0] k_r;
  tmb_pkg::in_item_t item_r;
  logic signed [DW-1:0] par_r [NP];
  logic signed [ACC_WIDTH-1:0] grad_r [NP];
  logic [ACC_WIDTH-1:0] loss_r;
  logic [15:0] rate_r;
  logic signed [DW-1:0] h_r, a1_r, a2_r, pred_r;
  logic signed [DW:0] c_r, d1_r, d2_r;
  logic signed [ACC_WIDTH:0] sum_r;
  logic out_valid_r;
  tmb_pkg::out_item_t out_r;
  tmb_pkg::out_item_t res_r;
  logic out_load;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod, prod_sh;

  tmb_mac #(.AW(MW), .BW(MW), .SH(FRAC_BITS)) u_mac (
    .clk(clk), .a(ma), .b(mb), .prod_r(prod), .prod_sh_r(prod_sh)
  );

  function automatic logic signed [DW-1:0] sat_d(input logic signed [ACC_WIDTH:0] v);
    logic signed [ACC_WIDTH:0] hi;
    hi = (ACC_WIDTH+1)'((64'sd1 <<< (DW-1)) - 1);
    if (v > hi) return DW'(hi);
    if (v < -hi - 1) return DW'(-hi - 1);
    return DW'(v);
  endfunction

  function automatic logic signed [DW:0] sat_sym1(input logic signed [PW:0] v);
    logic signed [PW:0] hi;
    hi = (PW+1)'((64'sd1 <<< DW) - 1);
    if (v > hi) return (DW+1)'(hi);
    if (v < -hi) return (DW+1)'(-hi);
    return (DW+1)'(v);
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] acc_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [PW-1:0] b);
    logic signed [ACC_WIDTH+PW:0] s;
    s = (ACC_WIDTH+PW+1)'(a) + (ACC_WIDTH+PW+1)'(b);
    if (s > (ACC_WIDTH+PW+1)'(AMAX)) return AMAX;
    if (s < (ACC_WIDTH+PW+1)'(AMIN)) return AMIN;
    return ACC_WIDTH'(s);
  endfunction

  // Update order: one multiply per parameter k, product lands next cycle.
  // Update split: g*r = (g>>>16)*r + ((g&0xFFFF)*r>>16); the high part is
  // taken as a saturated 18-bit value since only its clamp matters.
  logic signed [ACC_WIDTH-1:0] gk;
  logic signed [ACC_WIDTH-1:0] gh;
  logic [15:0] gl;
  logic signed [MW-1:0] gh_sat;
  logic [31:0] lo_prod;
  assign gk = grad_r[k_r];
  assign gh = gk >>> 16;
  assign gl = gk[15:0];
  assign gh_sat = (gh > ACC_WIDTH'(2**(MW-1)-1)) ? MW'(2**(MW-1)-1) :
                  (gh < -ACC_WIDTH'(2**(MW-1))) ? MW'(-(2**(MW-1))) : MW'(gh);
  assign lo_prod = {16'd0, gl} * {16'd0, rate_r};

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_FWD: begin
        case (step_r)
          5'd0: begin ma = MW'(par_r[0]); mb = MW'(item_r.sample_x1); end
          5'd1: begin ma = MW'(par_r[1]); mb = MW'(item_r.sample_x2); end
          5'd2: begin ma = MW'(par_r[2]); mb = MW'(item_r.sample_x1); end
          5'd3: begin ma = MW'(par_r[3]); mb = MW'(item_r.sample_x2); end
          5'd5: begin ma = MW'(a1_r); mb = MW'(par_r[4]); end
          5'd6: begin ma = MW'(a2_r); mb = MW'(par_r[5]); end
          5'd9: begin ma = MW'(pred_r) - MW'(item_r.target_value);
                      mb = MW'(pred_r) - MW'(item_r.target_value); end
          default: ;
        endcase
      end
      S_GRAD: begin
        case (step_r)
          5'd0: begin ma = MW'(c_r); mb = MW'(par_r[4]); end
          5'd1: begin ma = MW'(c_r); mb = MW'(par_r[5]); end
          5'd3: begin ma = MW'(d1_r); mb = MW'(item_r.sample_x1); end
          5'd4: begin ma = MW'(d1_r); mb = MW'(item_r.sample_x2); end
          5'd5: begin ma = MW'(d2_r); mb = MW'(item_r.sample_x1); end
          5'd6: begin ma = MW'(d2_r); mb = MW'(item_r.sample_x2); end
          5'd7: begin ma = MW'(c_r); mb = MW'(a1_r); end
          5'd8: begin ma = MW'(c_r); mb = MW'(a2_r); end
          default: ;
        endcase
      end
      S_UPD: begin
        ma = gh_sat;
        mb = MW'({1'b0, rate_r});
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  // Move the finished item to the output once the result register is free.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid && in_ready) begin
                 if (in_item.op == tmb_pkg::OP_TRAIN || in_item.op == tmb_pkg::OP_INFER)
                   state_nxt = S_FWD;
                 else
                   state_nxt = S_OUT;
               end
      S_FWD:   if (step_r == 5'd10)
                 state_nxt = (item_r.op == tmb_pkg::OP_TRAIN) ? S_GRAD : S_OUT;
      S_GRAD:  if (step_r == 5'd10) state_nxt = item_r.last_in_batch ? S_UPD : S_OUT;
      S_UPD:   if (step_r == 5'd1 && k_r == 4'(NP-1)) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic signed [ACC_WIDTH+1:0] delta_full;
  logic signed [DW+1:0] delta;
  logic signed [DW+2:0] newp;
  logic signed [PW:0] err2;
  logic signed [DW:0] errv;
  always_comb begin
    delta_full = (ACC_WIDTH+2)'(prod) + (ACC_WIDTH+2)'($signed({1'b0, lo_prod[31:16]}));
    if (delta_full > (ACC_WIDTH+2)'(2**(DW+1)-1)) delta = (DW+2)'(2**(DW+1)-1);
    else if (delta_full < -(ACC_WIDTH+2)'(2**(DW+1)-1)) delta = -(DW+2)'(2**(DW+1)-1);
    else delta = (DW+2)'(delta_full);
    newp = (DW+3)'(par_r[k_r]) - (DW+3)'(delta);
    errv = (DW+1)'(pred_r) - (DW+1)'(item_r.target_value);
    err2 = (PW+1)'(errv) * 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      loss_r      <= '0;
      rate_r      <= 16'd655;
      for (int i = 0; i < NP; i++) begin
        par_r[i]  <= '0;
        grad_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
      if (out_load) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          k_r    <= '0;
          if (in_valid && in_ready) begin
            item_r <= in_item;
            res_r  <= '0;
            if (in_item.op == tmb_pkg::OP_LOAD && in_item.param_index < 4'(NP))
              par_r[in_item.param_index] <= in_item.param_value;
          end
        end
        S_FWD: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd1: sum_r <= (ACC_WIDTH+1)'(prod_sh);
            5'd2: h_r <= sat_d(sum_r + (ACC_WIDTH+1)'(prod_sh) + (ACC_WIDTH+1)'(par_r[6]));
            5'd3: begin
              a1_r <= (h_r > 0) ? h_r : '0;
              sum_r <= (ACC_WIDTH+1)'(prod_sh);
            end
            5'd4: h_r <= sat_d(sum_r + (ACC_WIDTH+1)'(prod_sh) + (ACC_WIDTH+1)'(par_r[7]));
            5'd5: a2_r <= (h_r > 0) ? h_r : '0;
            5'd6: sum_r <= (ACC_WIDTH+1)'(prod_sh);
            5'd7: begin
              h_r <= sat_d(sum_r + (ACC_WIDTH+1)'(prod_sh) + (ACC_WIDTH+1)'(par_r[8]));
              pred_r <= '0;
            end
            5'd8: pred_r <= (h_r > 0) ? h_r : '0;
            5'd10: begin
              res_r.prediction    <= pred_r[14:0];
              res_r.squared_error <= (prod > PW'(64'hFFFFFFFF)) ? 32'hFFFFFFFF : prod[31:0];
              if (item_r.op == tmb_pkg::OP_TRAIN) begin
                if (LMAX - loss_r < ACC_WIDTH'(prod)) loss_r <= LMAX;
                else loss_r <= loss_r + ACC_WIDTH'(prod);
              end
              c_r <= (pred_r > 0) ? sat_sym1(err2) : '0;
              step_r <= '0;
            end
            default: ;
          endcase
        end
        S_GRAD: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd1: d1_r <= (a1_r > 0) ? sat_sym1((PW+1)'(prod_sh)) : '0;
            5'd2: d2_r <= (a2_r > 0) ? sat_sym1((PW+1)'(prod_sh)) : '0;
            5'd4: grad_r[0] <= acc_add(grad_r[0], prod_sh);
            5'd5: grad_r[1] <= acc_add(grad_r[1], prod_sh);
            5'd6: grad_r[2] <= acc_add(grad_r[2], prod_sh);
            5'd7: grad_r[3] <= acc_add(grad_r[3], prod_sh);
            5'd8: grad_r[4] <= acc_add(grad_r[4], prod_sh);
            5'd9: grad_r[5] <= acc_add(grad_r[5], prod_sh);
            5'd10: begin
              grad_r[6] <= acc_add(grad_r[6], PW'(d1_r));
              grad_r[7] <= acc_add(grad_r[7], PW'(d2_r));
              grad_r[8] <= acc_add(grad_r[8], PW'(c_r));
              step_r <= '0;
            end
            default: ;
          endcase
        end
        S_UPD: begin
          // step 0 issue multiply, step 1 apply to parameter k
          if (step_r == 5'd0) step_r <= 5'd1;
          else begin
            step_r <= '0;
            par_r[k_r] <= (newp > (DW+3)'(2**(DW-1)-1)) ? DW'(2**(DW-1)-1) :
                          (newp < -(DW+3)'(2**(DW-1))) ? DW'(-(2**(DW-1))) : DW'(newp);
            grad_r[k_r] <= '0;
            if (k_r == 4'(NP-1)) begin
              k_r <= '0;
              res_r.batch_loss <= loss_r;
              res_r.loss_valid <= 1'b1;
              loss_r <= '0;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `TMB_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ready)
  `TMB_ASSERT_NEXT(a_out_follows, clk, rst_n, state_r == S_OUT, out_valid)
  `TMB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
endmodule

// File: hw/rtl/tmb_mac.sv
// Shared multiplier with floor shift; registered product.
module tmb_mac #(
  parameter int AW = 18,
  parameter int BW = 18,
  parameter int SH = 12
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  prod_r,
  output logic signed [AW+BW-1:0]  prod_sh_r
);
  logic signed [AW+BW-1:0] p;
  assign p = a * b;
  always_ff @(posedge clk) begin
    prod_r    <= p;
    prod_sh_r <= p >>> SH;
  end
endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LIMIT_CYCLES = 1500000;
  localparam int  DRAIN_CYCLES = 60;
  localparam logic [39:0] ACC_MAX = 40'h7F_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tmb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tmb_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_ready_seen = 1'b0;

  tiny_mlp_batch_trainer_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: network weights, gradient sums, loss sum, step size.
  longint net_w[9];
  longint grad_acc[9];
  longint loss_sum;
  longint step_rate;

  tmb_pkg::in_item_t  pending_items[$];
  tmb_pkg::out_item_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;

  function automatic longint sat_signed(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint sat_mirror(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi ? -hi : v);
  endfunction

  function automatic longint acc_sat_add(longint a, longint b);
    return sat_signed(a + b, 40);
  endfunction

  // Floor-scale a gradient sum by the Q0.16 step size; products fit in 64 bits.
  function automatic longint rate_scale(longint g, longint r);
    return (g * r) >>> 16;
  endfunction

  // Run the network on one item, update predictor state, return expected result.
  function automatic tmb_pkg::out_item_t predict_item(tmb_pkg::in_item_t it);
    tmb_pkg::out_item_t r;
    longint x1, x2, t, h1, h2, a1, a2, o, pred, err, sq, c, d1, d2, dl;
    longint g[9];
    r = '0;
    if (it.op == tmb_pkg::OP_LOAD) begin
      if (it.param_index < 9) net_w[it.param_index] = longint'(it.param_value);
      return r;
    end
    if (it.op == tmb_pkg::OP_NONE) return r;
    x1 = longint'(it.sample_x1);
    x2 = longint'(it.sample_x2);
    t = longint'(it.target_value);
    h1 = sat_signed(((net_w[0] * x1) >>> 12) + ((net_w[1] * x2) >>> 12) + net_w[6], 16);
    h2 = sat_signed(((net_w[2] * x1) >>> 12) + ((net_w[3] * x2) >>> 12) + net_w[7], 16);
    a1 = h1 > 0 ? h1 : 0;
    a2 = h2 > 0 ? h2 : 0;
    o = sat_signed(((a1 * net_w[4]) >>> 12) + ((a2 * net_w[5]) >>> 12) + net_w[8], 16);
    pred = o > 0 ? o : 0;
    err = pred - t;
    sq = err * err;
    r.prediction = pred[14:0];
    r.squared_error = sq > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sq[31:0];
    if (it.op == tmb_pkg::OP_INFER) return r;
    loss_sum = (loss_sum + sq > ACC_MAX * 2 + 1) ? ACC_MAX * 2 + 1 : loss_sum + sq;
    c = pred > 0 ? sat_mirror(2 * err, 17) : 0;
    d1 = a1 > 0 ? sat_mirror((c * net_w[4]) >>> 12, 17) : 0;
    d2 = a2 > 0 ? sat_mirror((c * net_w[5]) >>> 12, 17) : 0;
    g[0] = (d1 * x1) >>> 12;
    g[1] = (d1 * x2) >>> 12;
    g[2] = (d2 * x1) >>> 12;
    g[3] = (d2 * x2) >>> 12;
    g[4] = (c * a1) >>> 12;
    g[5] = (c * a2) >>> 12;
    g[6] = d1;
    g[7] = d2;
    g[8] = c;
    foreach (grad_acc[k]) grad_acc[k] = acc_sat_add(grad_acc[k], g[k]);
    if (it.last_in_batch) begin
      foreach (net_w[k]) begin
        dl = sat_mirror(rate_scale(grad_acc[k], step_rate), 18);
        net_w[k] = sat_signed(net_w[k] - dl, 16);
        grad_acc[k] = 0;
      end
      r.batch_loss = loss_sum[39:0];
      r.loss_valid = 1'b1;
      loss_sum = 0;
    end
    return r;
  endfunction

  // Driver: hold valid and payload until accepted, then advance or go idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_ready_seen <= 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_item(in_item));
        in_ready_seen <= 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors <= errors + 1;
        end else if (out_item !== expected_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time,
                   expected_results[0], out_item);
          errors <= errors + 1;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic tmb_pkg::in_item_t rand_sample(bit training, bit last);
    tmb_pkg::in_item_t it;
    it = '0;
    it.op = training ? tmb_pkg::OP_TRAIN : tmb_pkg::OP_INFER;
    // Mostly small features keep the network in its working range.
    if ($urandom_range(9) == 0) begin
      it.sample_x1 = 16'($urandom);
      it.sample_x2 = 16'($urandom);
      it.target_value = 16'($urandom);
    end else begin
      it.sample_x1 = 16'($signed($urandom_range(16383)) - 8192);
      it.sample_x2 = 16'($signed($urandom_range(16383)) - 8192);
      it.target_value = 16'($signed($urandom_range(16383)) - 4096);
    end
    it.last_in_batch = last;
    it.param_index = 4'($urandom);
    it.param_value = 16'($urandom);
    return it;
  endfunction

  function automatic tmb_pkg::in_item_t load_item(int idx, int val);
    tmb_pkg::in_item_t it;
    it = '0;
    it.op = tmb_pkg::OP_LOAD;
    it.param_index = 4'(idx);
    it.param_value = 16'(val);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the step size between phases, with the block idle.
  task automatic write_rate(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_rate = longint'(v);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    int left, bsz;
    tmb_pkg::in_item_t it;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    left = n;
    while (left > 0) begin
      case ($urandom_range(9))
        0: begin
          it = load_item($urandom_range(15), $urandom);
          if ($urandom_range(3) == 0) it.op = tmb_pkg::OP_NONE;
          if ($urandom_range(1)) it.param_value = 16'($signed($urandom_range(8191)) - 2048);
          pending_items.push_back(it);
          left--;
        end
        1: begin
          pending_items.push_back(rand_sample(1'b0, $urandom_range(1)));
          left--;
        end
        default: begin
          bsz = $urandom_range(1, 6);
          for (int k = 0; k < bsz; k++)
            pending_items.push_back(rand_sample(1'b1, k == bsz - 1));
          left -= bsz;
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    tmb_pkg::in_item_t it;
    foreach (net_w[k]) begin
      net_w[k] = 0;
      grad_acc[k] = 0;
    end
    loss_sum = 0;
    step_rate = 655;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: loads of every parameter, some at extremes, then samples.
    for (int k = 0; k < 9; k++) pending_items.push_back(load_item(k, 16'sh1000));
    pending_items.push_back(load_item(4, 16'sh7FFF));
    pending_items.push_back(load_item(15, 16'sh8000));
    it = load_item(0, 0); it.op = tmb_pkg::OP_NONE; pending_items.push_back(it);
    it = rand_sample(1'b0, 1'b1);
    it.sample_x1 = 16'sh7FFF; it.sample_x2 = 16'sh7FFF; it.target_value = 16'sh8000;
    pending_items.push_back(it);
    it.op = tmb_pkg::OP_TRAIN; it.last_in_batch = 1'b0; pending_items.push_back(it);
    it.sample_x1 = 16'sh8000; it.sample_x2 = 16'sh8000; it.target_value = 16'sh7FFF;
    pending_items.push_back(it);
    it.sample_x1 = 16'sh0800; it.sample_x2 = 16'shF800; it.target_value = 0;
    it.last_in_batch = 1'b1; pending_items.push_back(it);
    pending_items.push_back(load_item(8, 16'sh8000));
    pending_items.push_back(rand_sample(1'b1, 1'b1));
    wait_drained();

    // Pause with nothing in flight, then sweep step sizes, idle and stall patterns.
    write_rate(16'hFFFF);
    random_phase(400, 0, 0);
    write_rate(16'h0000);
    random_phase(400, 83, 0);
    write_rate(16'($urandom));
    random_phase(400, 0, 83);
    write_rate(16'd655);
    random_phase(550, 24, 24);

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
